/* hw/rtl/spatial_stereo_mixer_unit_assert.svh */
// Assertion macros shared by the mixer RTL.
`ifndef SPATIAL_STEREO_MIXER_UNIT_ASSERT_SVH
`define SPATIAL_STEREO_MIXER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ssm_pkg.sv */
package ssm_pkg;

    localparam int SampleW = 16;
    localparam int IndexW  = 10;
    localparam int GainW   = 16;
    localparam logic [16:0] Unity = 17'd16384;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] CFG_LX = 3'd0;
    localparam logic [2:0] CFG_LY = 3'd1;
    localparam logic [2:0] CFG_LZ = 3'd2;
    localparam logic [2:0] CFG_FX = 3'd3;
    localparam logic [2:0] CFG_FZ = 3'd4;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [31:0]  source_x;
        logic signed [31:0]  source_y;
        logic signed [31:0]  source_z;
        logic [31:0]         max_range;
        logic [31:0]         ref_range;
        logic                positional;
        logic                playing;
        logic [IndexW-1:0]   frame_index;
        logic signed [SampleW-1:0] left_in;
        logic signed [SampleW-1:0] right_in;
    } ssm_in_t;

    typedef struct packed {
        logic [IndexW-1:0]         out_index;
        logic signed [SampleW-1:0] left_mix;
        logic signed [SampleW-1:0] right_mix;
    } ssm_out_t;

    // Request from the top level to the gain unit.
    typedef struct packed {
        logic               start;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [31:0]        max_range;
        logic [31:0]        ref_range;
        logic signed [17:0] fx;
        logic signed [17:0] fz;
    } ssm_gain_req_t;

    // Result of the gain unit.
    typedef struct packed {
        logic             done;
        logic             culled;
        logic [GainW-1:0] left_gain;
        logic [GainW-1:0] right_gain;
    } ssm_gain_rsp_t;

endpackage

/* hw/rtl/ssm_gain.sv */
module ssm_gain
    import ssm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ssm_gain_req_t req,
    output ssm_gain_rsp_t rsp
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAG   = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_PROJ  = 4'd5;
    localparam logic [3:0] ST_PDIV  = 4'd6;
    localparam logic [3:0] ST_FALL  = 4'd7;
    localparam logic [3:0] ST_FDIV  = 4'd8;
    localparam logic [3:0] ST_GAIN  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic signed [31:0] hx_reg, hy_reg, hz_reg;
    logic [31:0] ax_reg, ay_reg, az_reg;
    logic [63:0] sx_reg, sy_reg, sz_reg;
    logic [65:0] sum_reg;
    logic [65:0] rem_reg;
    logic [32:0] root_reg;
    logic [31:0] maxr_reg, refr_reg;
    logic signed [17:0] fx_reg, fz_reg;
    logic signed [50:0] pa_reg, pb_reg;
    logic        pneg_reg;
    logic [52:0] dnum_reg;
    logic [52:0] dquo_reg;
    logic [53:0] drem_reg;
    logic [33:0] dden_reg;
    logic [16:0] p_reg;
    logic [16:0] dv_reg;
    logic        culled_reg;

    function automatic logic signed [31:0] halve(input logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : d;
        m = m >> 1;
        return d[32] ? -32'(m) : 32'(m);
    endfunction

    // Restoring square root, one result bit per cycle (33 steps on a 66-bit radicand).
    logic [67:0] trial;
    logic [67:0] rem_shift;
    always_comb
    begin
        rem_shift = {rem_reg, sum_reg[65:64]};
        trial     = {rem_shift[67:0]} - {root_reg, 2'b01};
    end

    // Restoring divider step shared by projection and falloff.
    logic [53:0] dstep;
    logic [53:0] dsub;
    always_comb
    begin
        dstep = {drem_reg[52:0], dnum_reg[52]};
        dsub  = dstep - 54'(dden_reg);
    end

    logic [32:0] dist_val;
    assign dist_val = {root_reg[31:0], 1'b0};

    logic [33:0] lmul, rmul;
    logic [16:0] lg0, rg0;
    always_comb
    begin
        if (pneg_reg)
        begin
            lg0 = Unity - p_reg;
            rg0 = Unity;
        end
        else
        begin
            lg0 = Unity;
            rg0 = Unity - p_reg;
        end
        lmul = lg0 * dv_reg;
        rmul = rg0 * dv_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:  if (req.start) state_next = ST_MAG;
            ST_MAG:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_SUM;
            ST_SUM:
            begin
                state_next = ST_SQRT;
                cnt_next   = 6'd33;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                if (dist_val > {1'b0, maxr_reg}) state_next = ST_DONE;
                else if (root_reg == '0) state_next = ST_FALL;
                else
                begin
                    state_next = ST_PDIV;
                    cnt_next   = 6'd53;
                end
            end
            ST_PDIV:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) state_next = ST_FALL;
            end
            ST_FALL:
            begin
                if (dist_val > {1'b0, refr_reg} && maxr_reg > refr_reg)
                begin
                    state_next = ST_FDIV;
                    cnt_next   = 6'd53;
                end
                else state_next = ST_GAIN;
            end
            ST_FDIV:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) state_next = ST_GAIN;
            end
            ST_GAIN:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    logic signed [50:0] pdiff;
    assign pdiff = pa_reg - pb_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                hx_reg   <= halve(req.dx);
                hy_reg   <= halve(req.dy);
                hz_reg   <= halve(req.dz);
                maxr_reg <= req.max_range;
                refr_reg <= req.ref_range;
                if (req.fx == '0 && req.fz == '0)
                begin
                    fx_reg <= '0;
                    fz_reg <= 18'sd65536;
                end
                else
                begin
                    fx_reg <= req.fx;
                    fz_reg <= req.fz;
                end
                culled_reg <= 1'b0;
                p_reg      <= '0;
                pneg_reg   <= 1'b0;
                dv_reg     <= Unity;
            end
            ST_MAG:
            begin
                ax_reg <= hx_reg[31] ? 32'(-hx_reg) : 32'(hx_reg);
                ay_reg <= hy_reg[31] ? 32'(-hy_reg) : 32'(hy_reg);
                az_reg <= hz_reg[31] ? 32'(-hz_reg) : 32'(hz_reg);
                pa_reg <= 51'(fx_reg * hz_reg);
            end
            ST_SQ:
            begin
                sx_reg <= ax_reg * ax_reg;
                sy_reg <= ay_reg * ay_reg;
                sz_reg <= az_reg * az_reg;
                pb_reg <= 51'(fz_reg * hx_reg);
            end
            ST_SUM:
            begin
                sum_reg  <= 66'(sx_reg) + 66'(sy_reg) + 66'(sz_reg);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                sum_reg <= {sum_reg[63:0], 2'b00};
                if (!trial[67])
                begin
                    rem_reg  <= trial[65:0];
                    root_reg <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift[65:0];
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            ST_PROJ:
            begin
                if (dist_val > {1'b0, maxr_reg}) culled_reg <= 1'b1;
                pneg_reg <= pdiff[50];
                dnum_reg <= 53'(pdiff[50] ? -pdiff : pdiff);
                dden_reg <= {root_reg[31:0], 2'b00};
                drem_reg <= '0;
            end
            ST_PDIV, ST_FDIV:
            begin
                dnum_reg <= {dnum_reg[51:0], 1'b0};
                if (!dsub[53])
                begin
                    drem_reg <= dsub;
                    dquo_reg <= {dquo_reg[51:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dstep;
                    dquo_reg <= {dquo_reg[51:0], 1'b0};
                end
            end
            ST_FALL:
            begin
                if (root_reg != '0)
                begin
                    p_reg <= (dquo_reg > 53'(Unity)) ? Unity : dquo_reg[16:0];
                    if (dquo_reg == '0) pneg_reg <= 1'b0;
                end
                dnum_reg <= 53'({dist_val - {1'b0, refr_reg}, 14'd0});
                dden_reg <= 34'(maxr_reg - refr_reg);
                drem_reg <= '0;
            end
            ST_GAIN:
            begin
                if (dist_val > {1'b0, refr_reg} && maxr_reg > refr_reg)
                    dv_reg <= 17'(Unity - dquo_reg[16:0]);
            end
            default: ;
        endcase
    end

    // Gains are formed combinationally from the settled pan and falloff.
    assign rsp.done       = (state_reg == ST_DONE);
    assign rsp.culled     = culled_reg;
    assign rsp.left_gain  = culled_reg ? '0 : lmul[29:14];
    assign rsp.right_gain = culled_reg ? '0 : rmul[29:14];

endmodule

/* hw/rtl/spatial_stereo_mixer_unit.sv */
// An accepted read word reaches result through the stage-one registers, then the
// result register. Add and read words leave busy low, as does a non-positional
// begin word; a positional begin word holds busy high until the gain unit is done,
// past the square root when culled and at most through both dividers otherwise.
// After reset the store is cleared one frame a cycle with busy high.
// The receiver cannot stall; result_valid marks each result for one cycle.
`include "spatial_stereo_mixer_unit_assert.svh"
module spatial_stereo_mixer_unit
    import ssm_pkg::*;
#(
    parameter int FRAMES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ssm_in_t     item,
    output logic        result_valid,
    output ssm_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(FRAMES);
    localparam logic signed [SampleW:0] SMax = (SampleW+1)'((1 << (SampleW-1)) - 1);
    localparam logic signed [SampleW:0] SMin = -SMax - 1;

    // Configuration registers.
    logic signed [31:0] lx_reg, ly_reg, lz_reg;
    logic signed [17:0] fx_reg, fz_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg <= '0;
            ly_reg <= '0;
            lz_reg <= '0;
            fx_reg <= '0;
            fz_reg <= 18'sd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LX:  lx_reg <= cfg_data;
                CFG_LY:  ly_reg <= cfg_data;
                CFG_LZ:  lz_reg <= cfg_data;
                CFG_FX:  fx_reg <= cfg_data[17:0];
                CFG_FZ:  fz_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Source state.
    logic [GainW-1:0] lgain_reg, rgain_reg;
    logic live_reg, gain_wait_reg, playing_reg;

    // Clearing sweep after reset.
    logic [AW:0] clr_reg;
    logic        clearing;
    assign clearing = !clr_reg[AW];

    ssm_gain_req_t greq;
    ssm_gain_rsp_t grsp;

    logic accept;
    assign busy   = clearing || gain_wait_reg;
    assign accept = start && !busy;

    assign greq.start     = accept && item.command == CMD_BEGIN && item.positional;
    assign greq.dx        = 33'(item.source_x) - 33'(lx_reg);
    assign greq.dy        = 33'(item.source_y) - 33'(ly_reg);
    assign greq.dz        = 33'(item.source_z) - 33'(lz_reg);
    assign greq.max_range = item.max_range;
    assign greq.ref_range = item.ref_range;
    assign greq.fx        = fx_reg;
    assign greq.fz        = fz_reg;

    ssm_gain u_gain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (greq),
        .rsp   (grsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= 1'b0;
            gain_wait_reg <= 1'b0;
            playing_reg   <= 1'b0;
            lgain_reg     <= '0;
            rgain_reg     <= '0;
        end
        else if (gain_wait_reg)
        begin
            if (grsp.done)
            begin
                gain_wait_reg <= 1'b0;
                lgain_reg     <= grsp.left_gain;
                rgain_reg     <= grsp.right_gain;
                live_reg      <= playing_reg && !grsp.culled;
            end
        end
        else if (accept && item.command == CMD_BEGIN)
        begin
            playing_reg <= item.playing;
            if (item.positional)
            begin
                gain_wait_reg <= 1'b1;
                live_reg      <= 1'b0;
            end
            else
            begin
                lgain_reg <= GainW'(Unity);
                rgain_reg <= GainW'(Unity);
                live_reg  <= item.playing;
            end
        end
    end

    // Mix store with a registered read, then modify and write back in stage two.
    logic [2*SampleW-1:0] mem [FRAMES];
    logic [2*SampleW-1:0] rd_reg;
    logic                 s1_valid_reg;
    logic [1:0]           s1_cmd_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [IndexW-1:0]    s1_index_reg;
    logic signed [SampleW-1:0] s1_l_reg, s1_r_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [2*SampleW-1:0] wr_data;
    logic [AW-1:0]        rd_addr;

    assign rd_addr = AW'(item.frame_index % FRAMES);

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            clr_reg      <= '0;
        end
        else
        begin
            if (clearing) clr_reg <= clr_reg + 1'b1;
            s1_valid_reg <= accept &&
                ((item.command == CMD_ADD && live_reg) || item.command == CMD_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg   <= item.command;
        s1_addr_reg  <= rd_addr;
        s1_index_reg <= item.frame_index;
        s1_l_reg     <= item.left_in;
        s1_r_reg     <= item.right_in;
    end

    // Forward the word written last cycle when back-to-back words hit one frame.
    logic                 fwd_hit_reg;
    logic [2*SampleW-1:0] fwd_data_reg;
    logic [2*SampleW-1:0] cur;
    always_ff @(posedge clk)
    begin
        fwd_hit_reg  <= wr_en && wr_addr == rd_addr;
        fwd_data_reg <= wr_data;
    end
    assign cur = fwd_hit_reg ? fwd_data_reg : rd_reg;

    function automatic logic signed [SampleW-1:0] mix(
        input logic signed [SampleW-1:0] acc,
        input logic signed [SampleW-1:0] s,
        input logic [GainW-1:0]          g);
        logic signed [SampleW+GainW:0] prod;
        logic signed [SampleW:0]       sum;
        prod = s * $signed({1'b0, g});
        sum  = acc + (SampleW+1)'(prod >>> 14);
        if (sum > SMax) return SampleW'(SMax);
        if (sum < SMin) return SampleW'(SMin);
        return SampleW'(sum);
    endfunction

    logic signed [SampleW-1:0] cl, cr;
    assign cl = cur[SampleW-1:0];
    assign cr = cur[2*SampleW-1:SampleW];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = '0;
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
        end
        else if (s1_valid_reg)
        begin
            wr_en = 1'b1;
            if (s1_cmd_reg == CMD_ADD)
                wr_data = {mix(cr, s1_r_reg, rgain_reg), mix(cl, s1_l_reg, lgain_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) result_valid <= 1'b0;
        else        result_valid <= s1_valid_reg && s1_cmd_reg == CMD_READ;
    end

    always_ff @(posedge clk)
    begin
        result.out_index <= s1_index_reg;
        result.left_mix  <= cl;
        result.right_mix <= cr;
    end

    `SSM_ASSERT_IMP(a_no_accept_clear, clk, rst_n, clearing, !accept)
    `SSM_ASSERT_NEXT(a_read_result, clk, rst_n, s1_valid_reg && s1_cmd_reg == CMD_READ, result_valid)
    `SSM_ASSERT_IMP(a_gain_busy, clk, rst_n, gain_wait_reg, busy)

endmodule

/* dv/spatial_stereo_mixer_unit_tb.sv */
module spatial_stereo_mixer_unit_tb;
    import ssm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int InW = $bits(ssm_in_t);

    // Mix frame predictor and store of expected read words.
    class mix_scoreboard;
        logic signed [31:0] lis_x, lis_y, lis_z;
        logic signed [17:0] fac_x, fac_z;
        logic [31:0] frame_mem [1024];
        logic [15:0] gain_l, gain_r;
        bit live;
        ssm_out_t pending_reads[$];
        int errors;

        function void init();
            lis_x = '0;
            lis_y = '0;
            lis_z = '0;
            fac_x = '0;
            fac_z = 18'sd65536;
            foreach (frame_mem[i]) frame_mem[i] = '0;
            gain_l = '0;
            gain_r = '0;
            live = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_LX: lis_x = val;
                CFG_LY: lis_y = val;
                CFG_LZ: lis_z = val;
                CFG_FX: fac_x = val[17:0];
                CFG_FZ: fac_z = val[17:0];
                default: ;
            endcase
        endfunction

        static function longint halve(longint d);
            longint m;
            m = d < 0 ? -d : d;
            m = m >>> 1;
            return d < 0 ? -m : m;
        endfunction

        static function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void open_source(ssm_in_t w);
            longint hx, hy, hz, fx, fz, p;
            longint unsigned ax, ay, az, d15, dist_q, maxr, refr, lg, rg, dv;
            hx = halve(longint'(w.source_x) - longint'(lis_x));
            hy = halve(longint'(w.source_y) - longint'(lis_y));
            hz = halve(longint'(w.source_z) - longint'(lis_z));
            ax = hx < 0 ? -hx : hx;
            ay = hy < 0 ? -hy : hy;
            az = hz < 0 ? -hz : hz;
            d15 = root(ax * ax + ay * ay + az * az);
            dist_q = d15 << 1;
            maxr = w.max_range;
            refr = w.ref_range;
            fx = fac_x;
            fz = fac_z;
            p = 0;
            dv = 16384;
            if (!w.positional)
            begin
                gain_l = 16'd16384;
                gain_r = 16'd16384;
                live = w.playing;
                return;
            end
            if (dist_q > maxr)
            begin
                gain_l = '0;
                gain_r = '0;
                live = 1'b0;
                return;
            end
            // A zero facing vector is taken as straight ahead.
            if (fx == 0 && fz == 0) fz = 65536;
            if (d15 != 0)
            begin
                p = (fx * hz - fz * hx) / (4 * longint'(d15));
                if (p > 16384) p = 16384;
                if (p < -16384) p = -16384;
            end
            if (p < 0)
            begin
                lg = 16384 + p;
                rg = 16384;
            end
            else
            begin
                lg = 16384;
                rg = 16384 - p;
            end
            if (dist_q > refr && maxr > refr)
                dv = 16384 - (((dist_q - refr) << 14) / (maxr - refr));
            gain_l = 16'((lg * dv) >> 14);
            gain_r = 16'((rg * dv) >> 14);
            live = w.playing;
        endfunction

        static function logic [15:0] mix_in(logic signed [15:0] acc,
                                            logic signed [15:0] s, logic [15:0] g);
            longint v;
            v = longint'(acc) + ((longint'(s) * longint'({1'b0, g})) >>> 14);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_word(ssm_in_t w);
            ssm_out_t e;
            logic [31:0] f;
            f = frame_mem[w.frame_index];
            case (w.command)
                CMD_BEGIN: open_source(w);
                CMD_ADD:
                    if (live)
                        frame_mem[w.frame_index] = {mix_in(f[31:16], w.right_in, gain_r),
                                                    mix_in(f[15:0], w.left_in, gain_l)};
                CMD_READ:
                begin
                    e.out_index = w.frame_index;
                    e.left_mix = f[15:0];
                    e.right_mix = f[31:16];
                    pending_reads = {pending_reads, e};
                    frame_mem[w.frame_index] = '0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(ssm_out_t got);
            ssm_out_t e;
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result word index=%0d", got.out_index);
                errors++;
                return;
            end
            e = pending_reads.pop_front();
            if (got.out_index !== e.out_index)
            begin
                $error("out_index expected %0d actual %0d", e.out_index, got.out_index);
                errors++;
            end
            if (got.left_mix !== e.left_mix)
            begin
                $error("left_mix expected %0d actual %0d", e.left_mix, got.left_mix);
                errors++;
            end
            if (got.right_mix !== e.right_mix)
            begin
                $error("right_mix expected %0d actual %0d", e.right_mix, got.right_mix);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ssm_in_t item;
    logic result_valid;
    ssm_out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    mix_scoreboard mixsb;
    // Set before the final run of words so the sender stops inserting gaps.
    bit no_gaps;

    spatial_stereo_mixer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off, so every strobed cycle is checked right at the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            mixsb.check_word(result);
    end

    // Write one configuration register through its own handshake, mirroring it locally.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        mixsb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Present one word; it is accepted at the first edge with busy low.
    // The start line stays high across back-to-back words.
    task automatic send_word(ssm_in_t w);
        int gap;
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= w;
        do @(posedge clk); while (busy);
        mixsb.note_word(w);
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
        while (mixsb.pending_reads.size() != 0 || busy) @(posedge clk);
        // No begin word is still working here, since busy is low; the wait adds a quiet stretch.
        repeat (120) @(posedge clk);
    endtask

    function automatic ssm_in_t rand_word(bit well_formed);
        ssm_in_t w;
        w = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        // Small frame range most of the time so adds pile up and saturate.
        if ($urandom_range(0, 3) != 0) w.frame_index = 10'($urandom_range(0, 15));
        if (well_formed)
        begin
            case ($urandom_range(0, 19))
                0: w.command = CMD_BEGIN;
                1, 2, 3, 4, 5: w.command = CMD_READ;
                default: w.command = CMD_ADD;
            endcase
            if (w.command == CMD_BEGIN)
            begin
                // Keep most sources near the listener and inside their range.
                if ($urandom_range(0, 3) != 0)
                begin
                    w.source_x = mixsb.lis_x + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
                    w.source_y = mixsb.lis_y + $signed($urandom_range(0, 4 << 16)) - (2 << 16);
                    w.source_z = mixsb.lis_z + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
                    w.ref_range = $urandom_range(0, 5 << 16);
                    w.max_range = w.ref_range + $urandom_range(0, 20 << 16);
                    w.playing = $urandom_range(0, 7) != 0;
                end
            end
        end
        else if ($urandom_range(0, 3) == 0)
            w.command = 2'd3;
        return w;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_word(rand_word($urandom_range(0, 9) != 0));
    endtask

    task automatic directed();
        ssm_in_t w;
        w = '0;
        // Non-positional source at full scale; both extremes saturate.
        w.command = CMD_BEGIN; w.positional = 1'b0; w.playing = 1'b1;
        send_word(w);
        w.command = CMD_ADD; w.frame_index = 10'd1023;
        w.left_in = 16'sh7fff; w.right_in = 16'sh8000;
        send_word(w); send_word(w);
        w.command = CMD_READ; send_word(w); send_word(w);
        // Zero distance counts as centered.
        w.command = CMD_BEGIN; w.positional = 1'b1; w.max_range = 32'hffffffff;
        send_word(w);
        w.command = CMD_ADD; w.frame_index = 10'd0;
        w.left_in = 16'sd1000; w.right_in = -16'sd1000;
        send_word(w);
        w.command = CMD_READ; send_word(w);
        // Hard right, then hard left, with falloff between ref and max.
        w.command = CMD_BEGIN; w.source_x = 32'sd5 <<< 16; w.ref_range = 1 << 16;
        w.max_range = 10 << 16;
        send_word(w);
        w.command = CMD_ADD; w.frame_index = 10'd2;
        w.left_in = 16'sd20000; w.right_in = 16'sd20000;
        send_word(w);
        w.command = CMD_READ; send_word(w);
        w.command = CMD_BEGIN; w.source_x = -(32'sd5 <<< 16); send_word(w);
        w.command = CMD_ADD; send_word(w);
        w.command = CMD_READ; send_word(w);
        // Culled beyond max range: adds ignored.
        w.command = CMD_BEGIN; w.max_range = 1 << 16; send_word(w);
        w.command = CMD_ADD; send_word(w);
        w.command = CMD_READ; send_word(w);
        // Not playing, then unknown command.
        w.command = CMD_BEGIN; w.positional = 1'b0; w.playing = 1'b0; send_word(w);
        w.command = CMD_ADD; send_word(w);
        w.command = 2'd3; send_word(w);
        w.command = CMD_READ; send_word(w);
        // Extreme source positions.
        w.command = CMD_BEGIN; w.positional = 1'b1; w.playing = 1'b1;
        w.source_x = 32'sh7fffffff; w.source_y = 32'sh80000000; w.source_z = 32'sh7fffffff;
        w.max_range = 32'hffffffff; w.ref_range = 0;
        send_word(w);
        w.command = CMD_ADD; send_word(w);
        w.command = CMD_READ; send_word(w);
    endtask

    initial
    begin
        mixsb = new();
        mixsb.init();
        no_gaps = 0;
        start = 0;
        item = '0;
        cfg_valid = 0;
        cfg_index = CFG_LX;
        cfg_data = '0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Wait out the clearing pass of the store.
        @(posedge clk);
        while (busy) @(posedge clk);

        directed();
        go_idle();

        // Phase settings: extremes of every register, zero facing at the origin, then random ones.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_LX, 32'h7fffffff); write_reg(CFG_LY, 32'h80000000);
                    write_reg(CFG_LZ, 32'h7fffffff);
                    write_reg(CFG_FX, 32'd65536); write_reg(CFG_FZ, 32'd0);
                end
                1:
                begin
                    write_reg(CFG_LX, 32'h80000000); write_reg(CFG_LY, 32'h7fffffff);
                    write_reg(CFG_LZ, 32'h80000000);
                    write_reg(CFG_FX, -32'sd65536); write_reg(CFG_FZ, -32'sd65536);
                end
                2:
                begin
                    // Zero facing counts as straight ahead.
                    write_reg(CFG_FX, 32'd0); write_reg(CFG_FZ, 32'd0);
                    write_reg(CFG_LX, 32'd0); write_reg(CFG_LY, 32'd0);
                    write_reg(CFG_LZ, 32'd0);
                end
                default:
                begin
                    write_reg(CFG_LX, $urandom); write_reg(CFG_LY, $urandom);
                    write_reg(CFG_LZ, $urandom);
                    write_reg(CFG_FX, $urandom_range(0, 131072) - 65536);
                    write_reg(CFG_FZ, $urandom);
                end
            endcase
            run_random(250);
            go_idle();
        end

        no_gaps = 1;
        run_random(150);
        go_idle();

        if (mixsb.errors == 0 && mixsb.pending_reads.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_gain.sv
hw/rtl/spatial_stereo_mixer_unit.sv
dv/spatial_stereo_mixer_unit_tb.sv
